// ===== hdl/ckre_pkg.sv =====
package ckre_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned COL_W   = 12;   // column / row index
  localparam int unsigned DIM_W   = 13;   // dimension registers, exclusive right edge
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned IDX_W   = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_WIDTH = 3'd0,
    REG_ROW_COUNT = 3'd1,
    REG_RED_MIN   = 3'd2,
    REG_GREEN_MAX = 3'd3,
    REG_BLUE_MIN  = 3'd4
  } cfg_idx_e;

  localparam logic [DIM_W-1:0]  RST_ROW_WIDTH = DIM_W'(1);
  localparam logic [DIM_W-1:0]  RST_ROW_COUNT = DIM_W'(1);
  localparam logic [CHAN_W-1:0] RST_RED_MIN   = CHAN_W'(246);
  localparam logic [CHAN_W-1:0] RST_GREEN_MAX = CHAN_W'(9);
  localparam logic [CHAN_W-1:0] RST_BLUE_MIN  = CHAN_W'(246);

  typedef struct packed {
    logic [DIM_W-1:0]  row_width;
    logic [DIM_W-1:0]  row_count;
    logic [CHAN_W-1:0] red_min;
    logic [CHAN_W-1:0] green_max;
    logic [CHAN_W-1:0] blue_min;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] run_left;
    logic [DIM_W-1:0] run_right;
    logic [COL_W-1:0] run_row;
    logic             run_valid;
    logic             frame_end;
  } result_t;

  // zero acts as one, anything past MAX_DIM acts as MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage

// ===== hdl/ckre_scan.sv =====
// Raster position and open-run tracking; result is combinational off the
// accepted pixel, state advances on accept.
module ckre_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [ckre_pkg::CHAN_W-1:0] red_i,
  input  logic [ckre_pkg::CHAN_W-1:0] green_i,
  input  logic [ckre_pkg::CHAN_W-1:0] blue_i,
  input  ckre_pkg::cfg_t             cfg_i,
  output logic                       res_valid_o,
  output ckre_pkg::result_t          res_o
);

  logic [ckre_pkg::COL_W-1:0] col_q, col_d;
  logic [ckre_pkg::COL_W-1:0] row_q, row_d;
  logic [ckre_pkg::COL_W-1:0] start_q, start_d;
  logic                       open_q, open_d;

  logic [ckre_pkg::DIM_W-1:0] width, height, col_next, row_next;
  logic transparent, last_col, last_frame, emit;
  logic [ckre_pkg::COL_W-1:0] left;
  logic [ckre_pkg::DIM_W-1:0] right;

  assign width    = ckre_pkg::clamp_dim(cfg_i.row_width);
  assign height   = ckre_pkg::clamp_dim(cfg_i.row_count);
  assign col_next = {1'b0, col_q} + ckre_pkg::DIM_W'(1);
  assign row_next = {1'b0, row_q} + ckre_pkg::DIM_W'(1);

  assign transparent = (red_i > cfg_i.red_min) && (green_i < cfg_i.green_max)
                       && (blue_i > cfg_i.blue_min);
  assign last_col    = col_next >= width;
  assign last_frame  = last_col && (row_next >= height);

  always_comb begin
    emit    = 1'b0;
    left    = start_q;
    right   = {1'b0, col_q};
    start_d = start_q;
    open_d  = open_q;
    if (transparent) begin
      if (open_q) begin
        emit   = 1'b1;
        open_d = 1'b0;
      end
    end else begin
      if (!open_q) begin
        start_d = col_q;
        left    = col_q;
      end
      open_d = 1'b1;
      if (last_col) begin
        emit   = 1'b1;
        right  = col_next;
        open_d = 1'b0;
      end
    end
    col_d = col_q + ckre_pkg::COL_W'(1);
    row_d = row_q;
    if (last_frame) begin
      col_d  = '0;
      row_d  = '0;
      open_d = 1'b0;
    end else if (last_col) begin
      col_d  = '0;
      row_d  = row_next[ckre_pkg::COL_W-1:0];
      open_d = 1'b0;
    end
  end

  always_comb begin
    res_valid_o     = fire_i && (emit || last_frame);
    res_o.run_left  = emit ? left : '0;
    res_o.run_right = emit ? right : '0;
    res_o.run_row   = emit ? row_q : '0;
    res_o.run_valid = emit;
    res_o.frame_end = last_frame;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      start_q <= '0;
      open_q  <= 1'b0;
    end else if (fire_i) begin
      col_q   <= col_d;
      row_q   <= row_d;
      start_q <= start_d;
      open_q  <= open_d;
    end
  end

  a_open_start_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> start_q <= col_q)
    else $error("open run starts past current column");

  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.run_valid) |-> res_o.run_right > {1'b0, res_o.run_left})
    else $error("empty or inverted run");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && last_frame) |=> (col_q == '0 && row_q == '0 && !open_q))
    else $error("position did not wrap at frame end");

endmodule

// ===== hdl/color_key_run_extractor.sv =====
// Channel   Dir  Handshake              Payload
// cfg       in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
// pixel     in   in_valid_i/in_ready_o   red_i, green_i, blue_i
// run       out  out_valid_o/out_ready_i run_left_o, run_right_o, run_row_o,
//                                        run_valid_o, frame_end_o
//
// One pixel per clock sustained; a result lands in the output register, or in
// the skid while it stalls. Throughput is set by the output register plus a
// one-entry skid register: in_ready_o drops only while the skid holds a result.
// Reset clears position, run tracking and output valids; config returns to
// row_width 1, row_count 1, red_min 246, green_max 9, blue_min 246.
// Config writes are always taken (cfg_ready_o tied high); unknown indexes drop.
module color_key_run_extractor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ckre_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [ckre_pkg::DIM_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ckre_pkg::CHAN_W-1:0]  red_i,
  input  logic [ckre_pkg::CHAN_W-1:0]  green_i,
  input  logic [ckre_pkg::CHAN_W-1:0]  blue_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ckre_pkg::COL_W-1:0]   run_left_o,
  output logic [ckre_pkg::DIM_W-1:0]   run_right_o,
  output logic [ckre_pkg::COL_W-1:0]   run_row_o,
  output logic                         run_valid_o,
  output logic                         frame_end_o
);

  ckre_pkg::cfg_t    cfg_q;
  ckre_pkg::result_t res, out_q, skid_q;
  logic              res_valid, in_fire, out_fire;
  logic              out_valid_q, skid_valid_q;

  // ---- configuration registers ----
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_width <= ckre_pkg::RST_ROW_WIDTH;
      cfg_q.row_count <= ckre_pkg::RST_ROW_COUNT;
      cfg_q.red_min   <= ckre_pkg::RST_RED_MIN;
      cfg_q.green_max <= ckre_pkg::RST_GREEN_MAX;
      cfg_q.blue_min  <= ckre_pkg::RST_BLUE_MIN;
    end else if (cfg_valid_i) begin
      case (ckre_pkg::cfg_idx_e'(cfg_index_i))
        ckre_pkg::REG_ROW_WIDTH: cfg_q.row_width <= cfg_data_i;
        ckre_pkg::REG_ROW_COUNT: cfg_q.row_count <= cfg_data_i;
        ckre_pkg::REG_RED_MIN:   cfg_q.red_min   <= cfg_data_i[ckre_pkg::CHAN_W-1:0];
        ckre_pkg::REG_GREEN_MAX: cfg_q.green_max <= cfg_data_i[ckre_pkg::CHAN_W-1:0];
        ckre_pkg::REG_BLUE_MIN:  cfg_q.blue_min  <= cfg_data_i[ckre_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- pixel classification and run tracking ----
  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  ckre_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // ---- output register with skid ----
  // A new result lands in the output register when it is empty or draining,
  // otherwise in the skid; the skid refills the output as soon as it drains.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_valid_q && !out_ready_i) begin
      if (res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end else begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (out_valid_q && !out_ready_i) begin
      if (res_valid) begin
        skid_q <= res;
      end
    end else if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign run_left_o  = out_q.run_left;
  assign run_right_o = out_q.run_right;
  assign run_row_o   = out_q.run_row;
  assign run_valid_o = out_q.run_valid;
  assign frame_end_o = out_q.frame_end;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a run while output register is empty");

  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !run_valid_o) |->
      (frame_end_o && run_left_o == '0 && run_right_o == '0 && run_row_o == '0))
    else $error("result without run is not a clean frame-end marker");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_ready_i) |=> (skid_valid_q && $stable(skid_q)))
    else $error("skid contents lost while stalled");

endmodule

// ===== sim/color_key_run_extractor_test.sv =====
module color_key_run_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;

  // indexes past the last register, the block must drop these writes
  localparam logic [ckre_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [ckre_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                        clk_i;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [ckre_pkg::IDX_W-1:0]  cfg_index_i = '0;
  logic [ckre_pkg::DIM_W-1:0]  cfg_data_i  = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic [ckre_pkg::CHAN_W-1:0] red_i       = '0;
  logic [ckre_pkg::CHAN_W-1:0] green_i     = '0;
  logic [ckre_pkg::CHAN_W-1:0] blue_i      = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [ckre_pkg::COL_W-1:0]  run_left_o;
  logic [ckre_pkg::DIM_W-1:0]  run_right_o;
  logic [ckre_pkg::COL_W-1:0]  run_row_o;
  logic                        run_valid_o;
  logic                        frame_end_o;

  color_key_run_extractor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .run_left_o  (run_left_o),
    .run_right_o (run_right_o),
    .run_row_o   (run_row_o),
    .run_valid_o (run_valid_o),
    .frame_end_o (frame_end_o)
  );

  // Shadow of the block's registers and scan state.
  logic [ckre_pkg::DIM_W-1:0]  cfg_row_width = ckre_pkg::RST_ROW_WIDTH;
  logic [ckre_pkg::DIM_W-1:0]  cfg_row_count = ckre_pkg::RST_ROW_COUNT;
  logic [ckre_pkg::CHAN_W-1:0] cfg_red_min   = ckre_pkg::RST_RED_MIN;
  logic [ckre_pkg::CHAN_W-1:0] cfg_green_max = ckre_pkg::RST_GREEN_MAX;
  logic [ckre_pkg::CHAN_W-1:0] cfg_blue_min  = ckre_pkg::RST_BLUE_MIN;

  int unsigned scan_col   = 0;
  int unsigned scan_row   = 0;
  bit          run_active = 1'b0;
  int unsigned run_first  = 0;

  ckre_pkg::result_t runs_expected[$];
  int unsigned       mismatches = 0;

  // Idle controls: tx_gaps/rx_gaps enable random bursts, hold_req asks the
  // receiver for one long hold-off.
  bit          tx_gaps  = 1'b1;
  bit          rx_gaps  = 1'b1;
  int unsigned hold_req = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #3ms;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned eff_dim(input logic [ckre_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > ckre_pkg::MAX_DIM) return ckre_pkg::MAX_DIM;
    return 32'(v);
  endfunction

  // Advance the scan by one pixel and queue the run it closes, if any.
  task automatic predict_runs(input logic [ckre_pkg::CHAN_W-1:0] r, g, b);
    int unsigned       w, h, left, right;
    bit                keyed, last_col, last_frame, closes;
    ckre_pkg::result_t res;
    w          = eff_dim(cfg_row_width);
    h          = eff_dim(cfg_row_count);
    keyed      = (r > cfg_red_min) && (g < cfg_green_max) && (b > cfg_blue_min);
    // a column or row left past a shrunken dimension counts as the last one
    last_col   = (scan_col + 1) >= w;
    last_frame = last_col && ((scan_row + 1) >= h);
    closes     = 1'b0;
    left       = 0;
    right      = 0;
    if (keyed) begin
      if (run_active) begin
        closes     = 1'b1;
        left       = run_first;
        right      = scan_col;
        run_active = 1'b0;
      end
    end else begin
      if (!run_active) begin
        run_active = 1'b1;
        run_first  = scan_col;
      end
      if (last_col) begin
        closes     = 1'b1;
        left       = run_first;
        right      = scan_col + 1;
        run_active = 1'b0;
      end
    end
    if (closes || last_frame) begin
      // bare frame end carries zeros in the run fields
      res.run_left  = closes ? ckre_pkg::COL_W'(left) : '0;
      res.run_right = closes ? ckre_pkg::DIM_W'(right) : '0;
      res.run_row   = closes ? ckre_pkg::COL_W'(scan_row) : '0;
      res.run_valid = closes;
      res.frame_end = last_frame;
      runs_expected.push_back(res);
    end
    if (last_frame) begin
      scan_col   = 0;
      scan_row   = 0;
      run_active = 1'b0;
    end else if (last_col) begin
      scan_col   = 0;
      scan_row   = scan_row + 1;
      run_active = 1'b0;
    end else begin
      scan_col = scan_col + 1;
    end
  endtask

  // ---------------------------------------------------------------- drivers

  // Leaves cfg_valid_i high so back-to-back writes need no extra edge;
  // the caller drops it after the last write.
  task automatic write_reg(input logic [ckre_pkg::IDX_W-1:0] idx,
                           input logic [ckre_pkg::DIM_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      ckre_pkg::REG_ROW_WIDTH: cfg_row_width = data;
      ckre_pkg::REG_ROW_COUNT: cfg_row_count = data;
      ckre_pkg::REG_RED_MIN:   cfg_red_min   = data[ckre_pkg::CHAN_W-1:0];
      ckre_pkg::REG_GREEN_MAX: cfg_green_max = data[ckre_pkg::CHAN_W-1:0];
      ckre_pkg::REG_BLUE_MIN:  cfg_blue_min  = data[ckre_pkg::CHAN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [ckre_pkg::DIM_W-1:0] w, h, rmin, gmax, bmin);
    write_reg(ckre_pkg::REG_ROW_WIDTH, w);
    write_reg(ckre_pkg::REG_ROW_COUNT, h);
    write_reg(ckre_pkg::REG_RED_MIN, rmin);
    write_reg(ckre_pkg::REG_GREEN_MAX, gmax);
    write_reg(ckre_pkg::REG_BLUE_MIN, bmin);
    cfg_valid_i <= 1'b0;
  endtask

  // One pixel request. Valid stays high after acceptance; the next call
  // either keeps it up with a new payload or drops it for a gap.
  task automatic send_pixel(input logic [3*ckre_pkg::CHAN_W-1:0] pix);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {red_i, green_i, blue_i} <= pix;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_runs(pix[3*ckre_pkg::CHAN_W-1:2*ckre_pkg::CHAN_W],
                 pix[2*ckre_pkg::CHAN_W-1:ckre_pkg::CHAN_W],
                 pix[ckre_pkg::CHAN_W-1:0]);
  endtask

  // Stop offering pixels and let every pending run come out.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (runs_expected.size() != 0) @(posedge clk_i);
    // pixels that close no run may still be in flight
    repeat (4) @(posedge clk_i);
  endtask

  // Mix of key-colored pixels (some knocked onto a threshold, which keeps
  // them opaque) and fully random ones.
  function automatic logic [3*ckre_pkg::CHAN_W-1:0] pick_pixel(input int unsigned key_pct);
    logic [ckre_pkg::CHAN_W-1:0] r, g, b;
    if ($urandom_range(0, 99) < key_pct && cfg_red_min != 8'hFF && cfg_green_max != 8'h00
        && cfg_blue_min != 8'hFF) begin
      r = ckre_pkg::CHAN_W'($urandom_range(cfg_red_min + 1, 255));
      g = ckre_pkg::CHAN_W'($urandom_range(0, cfg_green_max - 1));
      b = ckre_pkg::CHAN_W'($urandom_range(cfg_blue_min + 1, 255));
      case ($urandom_range(0, 5))
        0: r = cfg_red_min;
        1: g = cfg_green_max;
        2: b = cfg_blue_min;
        default: ;
      endcase
    end else begin
      {r, g, b} = 24'($urandom);
    end
    return {r, g, b};
  endfunction

  // ---------------------------------------------------------------- receiver

  initial begin : rx_ready_ctrl
    int unsigned low_left;
    low_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        low_left = hold_req - 1;
        hold_req = 0;
        out_ready_i <= 1'b0;
      end else if (low_left != 0) begin
        low_left--;
        out_ready_i <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        low_left = $urandom_range(0, 16);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : run_checker
    ckre_pkg::result_t exp_run;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (runs_expected.size() == 0) begin
          $error("run result with none expected: left %0d right %0d row %0d valid %0b end %0b",
                 run_left_o, run_right_o, run_row_o, run_valid_o, frame_end_o);
          mismatches++;
        end else begin
          exp_run = runs_expected.pop_front();
          if (run_left_o !== exp_run.run_left) begin
            $error("run_left: expected %0d, got %0d", exp_run.run_left, run_left_o);
            mismatches++;
          end
          if (run_right_o !== exp_run.run_right) begin
            $error("run_right: expected %0d, got %0d", exp_run.run_right, run_right_o);
            mismatches++;
          end
          if (run_row_o !== exp_run.run_row) begin
            $error("run_row: expected %0d, got %0d", exp_run.run_row, run_row_o);
            mismatches++;
          end
          if (run_valid_o !== exp_run.run_valid) begin
            $error("run_valid: expected %0b, got %0b", exp_run.run_valid, run_valid_o);
            mismatches++;
          end
          if (frame_end_o !== exp_run.frame_end) begin
            $error("frame_end: expected %0b, got %0b", exp_run.frame_end, frame_end_o);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // 1x1 frame out of reset: every pixel is a frame end; thresholds are strict
  task automatic test_reset_defaults();
    send_pixel({8'd247, 8'd8, 8'd247});   // key color, bare frame end
    send_pixel({8'd246, 8'd8, 8'd247});   // red on threshold, opaque
    send_pixel({8'd247, 8'd9, 8'd247});   // green on threshold
    send_pixel({8'd247, 8'd8, 8'd246});   // blue on threshold
    send_pixel({8'd255, 8'd0, 8'd255});
    send_pixel({8'd0, 8'd255, 8'd0});
  endtask

  task automatic test_threshold_extremes();
    wait_idle();
    // red_min at top: nothing can be keyed
    apply_setting(13'd4, 13'd2, 13'h0FF, 13'd9, 13'd246);
    send_pixel({8'd255, 8'd0, 8'd255});
    send_pixel({8'd255, 8'd0, 8'd255});
    wait_idle();
    // widest key: any nonzero red and blue, green below full scale
    apply_setting(13'd4, 13'd2, 13'd0, 13'h1FFF, 13'd0);
    send_pixel({8'd0, 8'd0, 8'd0});
    send_pixel({8'd1, 8'd254, 8'd1});
    send_pixel({8'd255, 8'd255, 8'd255});
    send_pixel({8'd255, 8'd254, 8'd255});
    wait_idle();
    // zero dimensions act as one; green_max zero disables keying
    apply_setting(13'd0, 13'd0, 13'd0, 13'd0, 13'd0);
    send_pixel({8'd255, 8'd0, 8'd255});
    send_pixel({8'd128, 8'd128, 8'd128});
  endtask

  task automatic test_spare_index();
    wait_idle();
    for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) begin
      write_reg(ckre_pkg::IDX_W'(i), 13'h1FFF);
    end
    cfg_valid_i <= 1'b0;
    send_pixel({8'd255, 8'd0, 8'd255});
    send_pixel({8'd0, 8'd0, 8'd0});
  endtask

  // shrink both dimensions while the scan sits past them
  task automatic test_mid_frame_resize();
    wait_idle();
    apply_setting(13'd4, 13'd4, 13'd246, 13'd9, 13'd246);
    // realign: finish whatever frame is in progress from earlier tests
    while (scan_col != 0 || scan_row != 0) send_pixel({8'd255, 8'd0, 8'd255});
    repeat (6) send_pixel({8'd10, 8'd20, 8'd30});
    wait_idle();
    apply_setting(13'd2, 13'd1, 13'd246, 13'd9, 13'd246);
    send_pixel({8'd10, 8'd20, 8'd30});
    send_pixel({8'd10, 8'd20, 8'd30});
  endtask

  // dimensions at and above MAX_DIM; the next shrink ends the long row
  task automatic test_max_dims();
    wait_idle();
    apply_setting(13'h1FFF, 13'h1000, 13'd246, 13'd9, 13'd246);
    repeat (60) send_pixel(pick_pixel(20));
    wait_idle();
    apply_setting(13'd1, 13'h1FFF, 13'd246, 13'd9, 13'd246);
    repeat (40) send_pixel(pick_pixel(30));
  endtask

  // receiver holds off long while the sender keeps offering runs
  task automatic test_output_stall();
    wait_idle();
    tx_gaps = 1'b0;
    apply_setting(13'd1, 13'd4, 13'h0FF, 13'd9, 13'd246);
    hold_req = 150;
    repeat (40) send_pixel(pick_pixel(0));
    wait_idle();
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned                sent, seg_len, key_pct;
    logic [ckre_pkg::DIM_W-1:0] w, h;
    logic [ckre_pkg::DIM_W-1:0] th[3];
    sent = 0;
    while (sent < 450) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0:       w = '0;
        1:       w = ckre_pkg::DIM_W'($urandom_range(13, 40));
        default: w = ckre_pkg::DIM_W'($urandom_range(1, 12));
      endcase
      h = ckre_pkg::DIM_W'($urandom_range(0, 6));
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 7))
          0:       th[k] = '0;
          1:       th[k] = 13'h1FFF;
          default: th[k] = 13'($urandom);
        endcase
      end
      apply_setting(w, h, th[0], th[1], th[2]);
      seg_len = $urandom_range(40, 120);
      key_pct = $urandom_range(20, 80);
      repeat (seg_len) send_pixel(pick_pixel(key_pct));
      sent += seg_len;
    end
  endtask

  // closing stretch at full rate, no idling on either side
  task automatic test_full_rate();
    wait_idle();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    apply_setting(13'd5, 13'd3, 13'd200, 13'd60, 13'd200);
    repeat (150) send_pixel(pick_pixel(50));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_threshold_extremes();
    test_spare_index();
    test_mid_frame_resize();
    test_max_dims();
    test_output_stall();
    test_random_frames();
    test_full_rate();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ckre_pkg.sv
hdl/ckre_scan.sv
hdl/color_key_run_extractor.sv
sim/color_key_run_extractor_test.sv
